@@ src/pcbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the per-class box suppression unit.
// No dependencies; the files that use it refer to it by scoped names.
package pcbs_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int COORD_W       = 20;
    localparam int SCORE_W       = 16;
    localparam int CLASS_W       = 8;
    localparam int THR_W         = 16;
    localparam int AREA_W        = 2 * COORD_W;
    localparam int UNI_W         = AREA_W + 2;
    localparam int PROD_W        = UNI_W + THR_W;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;
    // register index of the overlap threshold
    localparam logic REG_THR_IDX = 1'b0;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [SCORE_W-1:0] score;
        logic [CLASS_W-1:0] class_id;
    } t_box;

    typedef enum logic [4:0] {
        S_LOAD,
        S_R_RDI,
        S_R_LATI,
        S_R_RDJ,
        S_R_CMPJ,
        S_R_WR,
        S_P_CHK,
        S_P_RB,
        S_P_EMIT,
        S_P_AREA,
        S_J_CHK,
        S_J_RB,
        S_J_LAT,
        S_J_M,
        S_J_U,
        S_J_P,
        S_J_CMP,
        S_FINAL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clr_i;
        logic inc_i;
        logic rd_box_i;
        logic lat_si;
        logic rd_box_j;
        logic cmp_j;
        logic wr_rank;
        logic rd_rank_i;
        logic rd_rank_j;
        logic rd_box_rank;
        logic push_a;
        logic area_a;
        logic set_j;
        logic inc_j;
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic out_load;
        logic out_last;
        logic end_set;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic i_last;
        logic i_end;
        logic j_last;
        logic j_end;
        logic mark_i;
        logic mark_j;
        logic have_pend;
        logic out_free;
    } t_status;

    // width of an interval, zero when the corners are reversed
    function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
        span = (hi > lo) ? (hi - lo) : '0;
    endfunction

endpackage

@@ src/pcbs_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcbs_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/pcbs_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: box and rank memories, counters, suppression marks, IoU test, output register.
// Depends on pcbs_pkg and pcbs_ram.
module pcbs_datapath #(
    parameter int MAX_BOXES = pcbs_pkg::MAX_BOXES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pcbs_pkg::t_cmd               i_cmd,
    output pcbs_pkg::t_status            o_st,
    input  pcbs_pkg::t_box               i_box,
    input  logic [pcbs_pkg::THR_W-1:0]   i_thr,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output pcbs_pkg::t_box               o_out_box,
    output logic                         o_out_ovf,
    output logic                         o_out_last
);
    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = AW + 1;
    localparam int BW = $bits(pcbs_pkg::t_box);

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [AW-1:0] r_cnt;
    logic [pcbs_pkg::SCORE_W-1:0] r_si;
    logic [MAX_BOXES-1:0] r_marks;
    logic          r_have_pend;
    pcbs_pkg::t_box r_a;
    logic [pcbs_pkg::AREA_W-1:0] r_area_a;

    // IoU pipeline registers
    logic                          r_match;
    logic [pcbs_pkg::COORD_W-1:0]  r_iw, r_ih, r_wb, r_hb;
    logic [pcbs_pkg::AREA_W-1:0]   r_inter, r_area_b;
    logic [pcbs_pkg::UNI_W-1:0]    r_uni1;
    logic [pcbs_pkg::PROD_W-1:0]   r_prod;

    // output register
    logic           r_ovalid;
    pcbs_pkg::t_box r_obox;
    logic           r_oovf;
    logic           r_olast;

    logic          box_re;
    logic [AW-1:0] box_raddr;
    logic [BW-1:0] box_rdata_raw;
    pcbs_pkg::t_box box_rd;
    logic          rank_re;
    logic [AW-1:0] rank_raddr;
    logic [AW-1:0] rank_rdata;
    logic          full;
    logic          rank_hit;
    logic [pcbs_pkg::COORD_W-1:0] x0, x1, y0, y1;
    logic [pcbs_pkg::PROD_W-1:0]  inter_sh;

    assign box_rd = pcbs_pkg::t_box'(box_rdata_raw);
    assign full   = (r_count == CW'(MAX_BOXES));

    // memory read address selection
    always_comb begin
        box_re     = i_cmd.rd_box_i | i_cmd.rd_box_j | i_cmd.rd_box_rank;
        box_raddr  = rank_rdata;
        if (i_cmd.rd_box_i) begin
            box_raddr = r_i[AW-1:0];
        end else if (i_cmd.rd_box_j) begin
            box_raddr = r_j[AW-1:0];
        end
        rank_re    = i_cmd.rd_rank_i | i_cmd.rd_rank_j;
        rank_raddr = i_cmd.rd_rank_i ? r_i[AW-1:0] : r_j[AW-1:0];
    end

    pcbs_ram #(.W(BW), .D(MAX_BOXES)) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load & ~full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (BW'(i_box)),
        .i_re    (box_re),
        .i_raddr (box_raddr),
        .o_rdata (box_rdata_raw)
    );

    pcbs_ram #(.W(AW), .D(MAX_BOXES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_rank),
        .i_waddr (r_cnt),
        .i_wdata (r_i[AW-1:0]),
        .i_re    (rank_re),
        .i_raddr (rank_raddr),
        .o_rdata (rank_rdata)
    );

    // rank: box j outranks box i on higher score, or equal score and earlier arrival
    assign rank_hit = (box_rd.score > r_si) || ((box_rd.score == r_si) && (r_j < r_i));

    // intersection corners of box a and the box just read
    assign x0 = (r_a.left > box_rd.left) ? r_a.left : box_rd.left;
    assign x1 = (r_a.right < box_rd.right) ? r_a.right : box_rd.right;
    assign y0 = (r_a.top > box_rd.top) ? r_a.top : box_rd.top;
    assign y1 = (r_a.bottom < box_rd.bottom) ? r_a.bottom : box_rd.bottom;
    assign inter_sh = {2'b00, r_inter, 16'h0000};

    // set bookkeeping and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
            r_marks     <= '0;
            r_have_pend <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.clr_i) begin
                r_i <= '0;
            end else if (i_cmd.inc_i) begin
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.lat_si) begin
                r_j   <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.cmp_j) begin
                r_j <= r_j + CW'(1);
                if (rank_hit) begin
                    r_cnt <= r_cnt + AW'(1);
                end
            end
            if (i_cmd.set_j) begin
                r_j <= r_i + CW'(1);
            end
            if (i_cmd.inc_j) begin
                r_j <= r_j + CW'(1);
            end
            if (i_cmd.s5 && r_match && (inter_sh > r_prod)) begin
                r_marks[r_j[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.push_a) begin
                r_have_pend <= 1'b1;
            end
            if (i_cmd.end_set) begin
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_marks     <= '0;
                r_have_pend <= 1'b0;
            end
        end
    end

    // payload registers: score of box i, box a and the IoU stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_si) begin
            r_si <= box_rd.score;
        end
        if (i_cmd.push_a) begin
            r_a <= box_rd;
        end
        if (i_cmd.area_a) begin
            r_area_a <= pcbs_pkg::span(r_a.left, r_a.right) * pcbs_pkg::span(r_a.top, r_a.bottom);
        end
        if (i_cmd.s1) begin
            r_match <= (box_rd.class_id == r_a.class_id);
            r_iw    <= pcbs_pkg::span(x0, x1);
            r_ih    <= pcbs_pkg::span(y0, y1);
            r_wb    <= pcbs_pkg::span(box_rd.left, box_rd.right);
            r_hb    <= pcbs_pkg::span(box_rd.top, box_rd.bottom);
        end
        if (i_cmd.s2) begin
            r_inter  <= r_iw * r_ih;
            r_area_b <= r_wb * r_hb;
        end
        if (i_cmd.s3) begin
            r_uni1 <= {2'b00, r_area_a} + {2'b00, r_area_b} - {2'b00, r_inter}
                      + pcbs_pkg::UNI_W'(1);
        end
        if (i_cmd.s4) begin
            r_prod <= {{pcbs_pkg::UNI_W{1'b0}}, i_thr} * {{pcbs_pkg::THR_W{1'b0}}, r_uni1};
        end
    end

    // output register: takes the pending box a
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_obox  <= r_a;
            r_oovf  <= r_ovf;
            r_olast <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_st.i_last    = ((r_i + CW'(1)) == r_count);
        o_st.i_end     = (r_i == r_count);
        o_st.j_last    = ((r_j + CW'(1)) == r_count);
        o_st.j_end     = (r_j == r_count);
        o_st.mark_i    = r_marks[r_i[AW-1:0]];
        o_st.mark_j    = r_marks[r_j[AW-1:0]];
        o_st.have_pend = r_have_pend;
        o_st.out_free  = ~r_ovalid | i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_box   = r_obox;
    assign o_out_ovf   = r_oovf;
    assign o_out_last  = r_olast;
endmodule

@@ src/pcbs_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences loading, ranking and the greedy suppression walk.
// Depends on pcbs_pkg.
module pcbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_last_in,
    output logic              o_ready,
    input  pcbs_pkg::t_status i_st,
    output pcbs_pkg::t_cmd    o_cmd
);
    pcbs_pkg::t_state r_state;
    pcbs_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcbs_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            pcbs_pkg::S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_in) begin
                        o_cmd.clr_i = 1'b1;
                        n_state     = pcbs_pkg::S_R_RDI;
                    end
                end
            end
            pcbs_pkg::S_R_RDI: begin
                o_cmd.rd_box_i = 1'b1;
                n_state        = pcbs_pkg::S_R_LATI;
            end
            pcbs_pkg::S_R_LATI: begin
                o_cmd.lat_si = 1'b1;
                n_state      = pcbs_pkg::S_R_RDJ;
            end
            pcbs_pkg::S_R_RDJ: begin
                o_cmd.rd_box_j = 1'b1;
                n_state        = pcbs_pkg::S_R_CMPJ;
            end
            pcbs_pkg::S_R_CMPJ: begin
                o_cmd.cmp_j = 1'b1;
                n_state     = i_st.j_last ? pcbs_pkg::S_R_WR : pcbs_pkg::S_R_RDJ;
            end
            pcbs_pkg::S_R_WR: begin
                o_cmd.wr_rank = 1'b1;
                if (i_st.i_last) begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = pcbs_pkg::S_P_CHK;
                end else begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = pcbs_pkg::S_R_RDI;
                end
            end
            pcbs_pkg::S_P_CHK: begin
                if (i_st.i_end) begin
                    n_state = pcbs_pkg::S_FINAL;
                end else if (i_st.mark_i) begin
                    o_cmd.inc_i = 1'b1;
                end else begin
                    o_cmd.rd_rank_i = 1'b1;
                    n_state         = pcbs_pkg::S_P_RB;
                end
            end
            pcbs_pkg::S_P_RB: begin
                o_cmd.rd_box_rank = 1'b1;
                n_state           = pcbs_pkg::S_P_EMIT;
            end
            pcbs_pkg::S_P_EMIT: begin
                // previous kept box goes out before box a replaces it
                if (!i_st.have_pend || i_st.out_free) begin
                    o_cmd.push_a   = 1'b1;
                    o_cmd.out_load = i_st.have_pend;
                    n_state        = pcbs_pkg::S_P_AREA;
                end
            end
            pcbs_pkg::S_P_AREA: begin
                o_cmd.area_a = 1'b1;
                o_cmd.set_j  = 1'b1;
                n_state      = pcbs_pkg::S_J_CHK;
            end
            pcbs_pkg::S_J_CHK: begin
                if (i_st.j_end) begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = pcbs_pkg::S_P_CHK;
                end else if (i_st.mark_j) begin
                    o_cmd.inc_j = 1'b1;
                end else begin
                    o_cmd.rd_rank_j = 1'b1;
                    n_state         = pcbs_pkg::S_J_RB;
                end
            end
            pcbs_pkg::S_J_RB: begin
                o_cmd.rd_box_rank = 1'b1;
                n_state           = pcbs_pkg::S_J_LAT;
            end
            pcbs_pkg::S_J_LAT: begin
                o_cmd.s1 = 1'b1;
                n_state  = pcbs_pkg::S_J_M;
            end
            pcbs_pkg::S_J_M: begin
                o_cmd.s2 = 1'b1;
                n_state  = pcbs_pkg::S_J_U;
            end
            pcbs_pkg::S_J_U: begin
                o_cmd.s3 = 1'b1;
                n_state  = pcbs_pkg::S_J_P;
            end
            pcbs_pkg::S_J_P: begin
                o_cmd.s4 = 1'b1;
                n_state  = pcbs_pkg::S_J_CMP;
            end
            pcbs_pkg::S_J_CMP: begin
                o_cmd.s5    = 1'b1;
                o_cmd.inc_j = 1'b1;
                n_state     = pcbs_pkg::S_J_CHK;
            end
            pcbs_pkg::S_FINAL: begin
                if (!i_st.have_pend) begin
                    o_cmd.end_set = 1'b1;
                    n_state       = pcbs_pkg::S_LOAD;
                end else if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.end_set  = 1'b1;
                    n_state        = pcbs_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = pcbs_pkg::S_LOAD;
            end
        endcase
    end
endmodule

@@ src/per_class_box_suppression_unit.sv @@
`timescale 1ns / 1ps
// Top level of the per-class box suppression unit: APB threshold register,
// controller and datapath. Depends on pcbs_pkg, pcbs_ctrl, pcbs_datapath.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_left i_top i_right i_bottom i_score
//                                            i_class_id i_last_in
//  output    out        o_valid / i_ready   o_kept_* o_overflow o_last_out
//  config    in         APB psel/penable    paddr pwdata prdata (threshold at 0x0)
//
// While loading, a box beat is taken whenever i_valid is high. After the last beat the set
// is ranked (one box memory read port, pairwise compare), then walked greedily: each kept
// rank is tested against every later unmarked rank of the set, one pair at a time through
// the shared IoU unit, and a closing state then emits the final result.
// No input beat is taken from the last beat until the final result is loaded.
// A stalled output holds the walk only when the next kept box must go out.
// Reset (synchronous, active low) empties the set; memories are not cleared.
module per_class_box_suppression_unit #(
    parameter int MAX_BOXES = pcbs_pkg::MAX_BOXES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [pcbs_pkg::COORD_W-1:0]         i_left,
    input  logic [pcbs_pkg::COORD_W-1:0]         i_top,
    input  logic [pcbs_pkg::COORD_W-1:0]         i_right,
    input  logic [pcbs_pkg::COORD_W-1:0]         i_bottom,
    input  logic [pcbs_pkg::SCORE_W-1:0]         i_score,
    input  logic [pcbs_pkg::CLASS_W-1:0]         i_class_id,
    input  logic                                 i_last_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [pcbs_pkg::COORD_W-1:0]         o_kept_left,
    output logic [pcbs_pkg::COORD_W-1:0]         o_kept_top,
    output logic [pcbs_pkg::COORD_W-1:0]         o_kept_right,
    output logic [pcbs_pkg::COORD_W-1:0]         o_kept_bottom,
    output logic [pcbs_pkg::SCORE_W-1:0]         o_kept_score,
    output logic [pcbs_pkg::CLASS_W-1:0]         o_kept_class,
    output logic                                 o_overflow,
    output logic                                 o_last_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pcbs_pkg::PADDR_W-1:0]         paddr,
    input  logic [pcbs_pkg::PDATA_W-1:0]         pwdata,
    output logic [pcbs_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    logic [pcbs_pkg::THR_W-1:0] r_thr;
    pcbs_pkg::t_cmd    cmd;
    pcbs_pkg::t_status st;
    pcbs_pkg::t_box    in_box;
    pcbs_pkg::t_box    out_box;
    logic              thr_sel;

    // threshold register
    assign pready  = 1'b1;
    assign thr_sel = (paddr[2] == pcbs_pkg::REG_THR_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= pcbs_pkg::THR_RESET;
        end else if (psel && penable && pwrite && thr_sel) begin
            r_thr <= pwdata[pcbs_pkg::THR_W-1:0];
        end
    end

    assign prdata = thr_sel ? pcbs_pkg::PDATA_W'(r_thr) : '0;

    always_comb begin
        in_box.left     = i_left;
        in_box.top      = i_top;
        in_box.right    = i_right;
        in_box.bottom   = i_bottom;
        in_box.score    = i_score;
        in_box.class_id = i_class_id;
    end

    pcbs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_last_in (i_last_in),
        .o_ready   (o_ready),
        .i_st      (st),
        .o_cmd     (cmd)
    );

    pcbs_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_box       (in_box),
        .i_thr       (r_thr),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_out_box   (out_box),
        .o_out_ovf   (o_overflow),
        .o_out_last  (o_last_out)
    );

    assign o_kept_left   = out_box.left;
    assign o_kept_top    = out_box.top;
    assign o_kept_right  = out_box.right;
    assign o_kept_bottom = out_box.bottom;
    assign o_kept_score  = out_box.score;
    assign o_kept_class  = out_box.class_id;

    // result register is never overwritten while a beat waits
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || i_ready))
        else $error("result overwritten while stalled");

    // the final result always comes from a pending kept box
    a_last_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && cmd.out_last) |-> st.have_pend)
        else $error("final result without a kept box");

    // a closing beat takes o_ready low once it is accepted
    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_in) |=> !o_ready)
        else $error("intake reopened right after set close");
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for per_class_box_suppression_unit: box sets in,
// surviving boxes out, checked against a greedy per-class suppression predictor.
// Depends on pcbs_pkg and the RTL of the unit.
module testbench;

    localparam int NBOX     = pcbs_pkg::MAX_BOXES_DEF;
    localparam int LIMIT    = 1000000;
    localparam int SETTLE   = 3000;

    typedef struct {
        pcbs_pkg::t_box b;
        logic ovf;
        logic last;
    } t_kept;

    typedef struct {
        pcbs_pkg::t_box b;
        logic  last;
        bit    typed;
        t_kept want;
    } t_dir_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [pcbs_pkg::COORD_W-1:0]   i_left, i_top, i_right, i_bottom;
    logic [pcbs_pkg::SCORE_W-1:0]   i_score;
    logic [pcbs_pkg::CLASS_W-1:0]   i_class_id;
    logic                           i_last_in;
    logic                           o_valid;
    logic                           i_ready;
    logic [pcbs_pkg::COORD_W-1:0]   o_kept_left, o_kept_top, o_kept_right, o_kept_bottom;
    logic [pcbs_pkg::SCORE_W-1:0]   o_kept_score;
    logic [pcbs_pkg::CLASS_W-1:0]   o_kept_class;
    logic                           o_overflow;
    logic                           o_last_out;
    logic                           psel, penable, pwrite;
    logic [pcbs_pkg::PADDR_W-1:0]   paddr;
    logic [pcbs_pkg::PDATA_W-1:0]   pwdata;
    logic [pcbs_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    per_class_box_suppression_unit uut (.*);

    // predictor state
    pcbs_pkg::t_box             set_store [NBOX];
    int                         set_count;
    bit                         set_ovf;
    logic [pcbs_pkg::THR_W-1:0] thr_model;

    t_kept            kept_expected [$];
    int               mismatches;
    int               cycles;
    bit               calm;
    int               beats_sent;
    t_dir_row         dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic longint unsigned span64(input logic [pcbs_pkg::COORD_W-1:0] lo,
                                               input logic [pcbs_pkg::COORD_W-1:0] hi);
        return (hi > lo) ? longint'(hi - lo) : 64'd0;
    endfunction

    // division-free IoU test between stored boxes a and b
    function automatic bit iou_exceeds(input pcbs_pkg::t_box a, input pcbs_pkg::t_box b);
        longint unsigned iw, ih, inter, ar_a, ar_b, uni;
        logic [pcbs_pkg::COORD_W-1:0] l, r, t, d;
        l = (a.left > b.left) ? a.left : b.left;
        r = (a.right < b.right) ? a.right : b.right;
        t = (a.top > b.top) ? a.top : b.top;
        d = (a.bottom < b.bottom) ? a.bottom : b.bottom;
        iw = span64(l, r);
        ih = span64(t, d);
        inter = iw * ih;
        ar_a = span64(a.left, a.right) * span64(a.top, a.bottom);
        ar_b = span64(b.left, b.right) * span64(b.top, b.bottom);
        uni = ar_a + ar_b - inter;
        return (inter << 16) > longint'(thr_model) * (uni + 1);
    endfunction

    // store one box; on the closing box rank the set and walk it greedily
    task automatic survivors_of(input pcbs_pkg::t_box b, input logic last,
                                ref t_kept res [$]);
        int order [NBOX];
        bit gone [NBOX];
        int n, k, last_idx;
        res.delete();
        if (set_count < NBOX) begin
            set_store[set_count] = b;
            set_count++;
        end else begin
            set_ovf = 1'b1;
        end
        if (!last) return;
        n = set_count;
        for (int i = 0; i < n; i++) begin
            k = i;
            while (k > 0 && set_store[order[k-1]].score < set_store[i].score) begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = i;
            gone[i] = 1'b0;
        end
        last_idx = -1;
        for (int i = 0; i < n; i++) begin
            t_kept kb;
            if (gone[i]) continue;
            kb.b = set_store[order[i]];
            kb.ovf = set_ovf;
            kb.last = 1'b0;
            res = {res, kb};
            last_idx++;
            for (int j = i + 1; j < n; j++) begin
                if (gone[j]) continue;
                if (set_store[order[j]].class_id != kb.b.class_id) continue;
                if (iou_exceeds(kb.b, set_store[order[j]])) gone[j] = 1'b1;
            end
        end
        if (last_idx >= 0) res[last_idx].last = 1'b1;
        set_count = 0;
        set_ovf = 1'b0;
    endtask

    // one input beat, with random idle before it
    task automatic send_box(input pcbs_pkg::t_box b, input logic last,
                            input bit typed, input t_kept want);
        t_kept res [$];
        if (!calm && $urandom_range(99) < 9) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_left     <= b.left;
        i_top      <= b.top;
        i_right    <= b.right;
        i_bottom   <= b.bottom;
        i_score    <= b.score;
        i_class_id <= b.class_id;
        i_last_in  <= last;
        do @(posedge i_clk); while (!o_ready);
        beats_sent++;
        survivors_of(b, last, res);
        if (typed) kept_expected = {kept_expected, want};
        else foreach (res[i]) kept_expected = {kept_expected, res[i]};
    endtask

    // drop valid right after the last accepted beat, then wait for every result
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (kept_expected.size() != 0) @(posedge i_clk);
    endtask

    // threshold write, then read back; only while idle
    task automatic write_thr(input logic [pcbs_pkg::THR_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 1'b0;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= '0; pwdata <= {$urandom} & 32'hFFFF_0000 | v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        thr_model = v;
        @(negedge i_clk);
        penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[pcbs_pkg::THR_W-1:0] !== v)
            report($sformatf("threshold read %h, wrote %h", prdata, v));
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic pcbs_pkg::t_box rand_box(input int cx, input int cy, input int mode);
        pcbs_pkg::t_box b;
        int w, h;
        if (mode == 0) begin
            b.left     = pcbs_pkg::COORD_W'($urandom);
            b.top      = pcbs_pkg::COORD_W'($urandom);
            b.right    = pcbs_pkg::COORD_W'($urandom);
            b.bottom   = pcbs_pkg::COORD_W'($urandom);
            b.score    = pcbs_pkg::SCORE_W'($urandom);
            b.class_id = pcbs_pkg::CLASS_W'($urandom);
        end else begin
            w = $urandom_range(1, 400);
            h = $urandom_range(1, 400);
            b.left   = pcbs_pkg::COORD_W'(cx + $urandom_range(60));
            b.top    = pcbs_pkg::COORD_W'(cy + $urandom_range(60));
            b.right  = pcbs_pkg::COORD_W'(b.left + w);
            b.bottom = pcbs_pkg::COORD_W'(b.top + h);
            if ($urandom_range(19) == 0) begin
                b.right = pcbs_pkg::COORD_W'(b.left - $urandom_range(50));
            end
            b.score = ($urandom_range(3) == 0) ? 16'($urandom_range(4) * 100)
                                               : 16'($urandom);
            b.class_id = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        end
        return b;
    endfunction

    // one box set of n beats; beat n carries the close marker
    task automatic run_set(input int n);
        int cx, cy;
        t_kept none;
        cx = $urandom;
        cy = $urandom;
        for (int i = 0; i < n; i++)
            send_box(rand_box(cx, cy, ($urandom_range(9) == 0) ? 0 : 1),
                     i == n - 1, 1'b0, none);
    endtask

    task automatic run_random(input int beats, input bit pause_between);
        int goal;
        goal = beats_sent + beats;
        while (beats_sent < goal) begin
            run_set(($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8));
            if (pause_between) wait_drained();
        end
    endtask

    task automatic add_row(input logic [pcbs_pkg::COORD_W-1:0] l, t, r, d,
                           input logic [pcbs_pkg::SCORE_W-1:0] s,
                           input logic [pcbs_pkg::CLASS_W-1:0] c,
                           input logic last, input bit typed);
        t_dir_row row;
        row.b = '{left: l, top: t, right: r, bottom: d, score: s, class_id: c};
        row.last = last;
        row.typed = typed;
        // a lone box always survives as the single closing result
        row.want.b = row.b;
        row.want.ovf = 1'b0;
        row.want.last = 1'b1;
        dir_rows = {dir_rows, row};
    endtask

    // output side: random stall, compare every beat with the oldest expectation
    always @(negedge i_clk)
        if (i_rst_n) i_ready <= calm || ($urandom_range(99) >= 9);

    always @(posedge i_clk) begin
        t_kept w;
        if (i_rst_n && o_valid && i_ready) begin
            if (kept_expected.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                w = kept_expected.pop_front();
                if (o_kept_left !== w.b.left)
                    report($sformatf("left %h want %h", o_kept_left, w.b.left));
                if (o_kept_top !== w.b.top)
                    report($sformatf("top %h want %h", o_kept_top, w.b.top));
                if (o_kept_right !== w.b.right)
                    report($sformatf("right %h want %h", o_kept_right, w.b.right));
                if (o_kept_bottom !== w.b.bottom)
                    report($sformatf("bottom %h want %h", o_kept_bottom, w.b.bottom));
                if (o_kept_score !== w.b.score)
                    report($sformatf("score %h want %h", o_kept_score, w.b.score));
                if (o_kept_class !== w.b.class_id)
                    report($sformatf("class %h want %h", o_kept_class, w.b.class_id));
                if (o_overflow !== w.ovf)
                    report($sformatf("overflow %b want %b", o_overflow, w.ovf));
                if (o_last_out !== w.last)
                    report($sformatf("last_out %b want %b", o_last_out, w.last));
            end
        end
    end

    initial begin
        cycles = 0; mismatches = 0; beats_sent = 0; calm = 1'b0;
        set_count = 0; set_ovf = 1'b0; thr_model = pcbs_pkg::THR_RESET;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0;
        i_left = '0; i_top = '0; i_right = '0; i_bottom = '0;
        i_score = '0; i_class_id = '0; i_last_in = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, reversed corners, ties, classes, zero area, overlap
        add_row(20'h0, 20'h0, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        add_row(20'h0, 20'h0, 20'h0, 20'h0, 16'h0, 8'h0, 1'b1, 1'b1);
        add_row(20'hFFFFF, 20'hFFFFF, 20'h0, 20'h0, 16'h1, 8'h55, 1'b1, 1'b1);
        add_row(20'd100, 20'd100, 20'd500, 20'd500, 16'd300, 8'd7, 1'b0, 1'b0);
        add_row(20'd100, 20'd100, 20'd500, 20'd500, 16'd300, 8'd7, 1'b0, 1'b0);
        add_row(20'd100, 20'd100, 20'd500, 20'd500, 16'd900, 8'd7, 1'b1, 1'b0);
        add_row(20'd10, 20'd10, 20'd90, 20'd90, 16'd5, 8'd1, 1'b0, 1'b0);
        add_row(20'd10, 20'd10, 20'd90, 20'd90, 16'd5, 8'd2, 1'b1, 1'b0);
        add_row(20'd200, 20'd200, 20'd200, 20'd400, 16'hFFFF, 8'd3, 1'b0, 1'b0);
        add_row(20'd200, 20'd200, 20'd200, 20'd400, 16'd10, 8'd3, 1'b1, 1'b0);
        add_row(20'd0, 20'd0, 20'd160, 20'd160, 16'd1000, 8'd4, 1'b0, 1'b0);
        add_row(20'd80, 20'd0, 20'd240, 20'd160, 16'd2000, 8'd4, 1'b0, 1'b0);
        add_row(20'd0, 20'd0, 20'd160, 20'd161, 16'd1500, 8'd4, 1'b1, 1'b0);
        foreach (dir_rows[i])
            send_box(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

        run_random(30, 1'b0);

        // any overlap at all suppresses
        write_thr(16'h0000);
        run_random(40, 1'b1);

        // nearly nothing suppresses; no stalls on either side
        write_thr(16'hFFFF);
        calm = 1'b1;
        run_random(40, 1'b0);
        calm = 1'b0;

        // full store with the close on a kept beat, then overflow with the close on a dropped beat
        write_thr(16'($urandom));
        run_set(NBOX);
        run_set(NBOX + 2);
        run_set(NBOX + 6);
        run_random(40, 1'b0);

        write_thr(pcbs_pkg::THR_RESET);
        run_random(20, 1'b0);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
